[hdl/urs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urs_pkg: shared types and constants for the ultrasonic range core
// Item layouts, configuration block, phase encoding and scaling constants.
// ----------------------------------------------------------------------------
package urs_pkg;

  // Register indexes on the configuration port.
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_TRIGGER_TICKS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ECHO_TIMEOUT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_STOP_THRESH   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [15:0] TRIGGER_TICKS_RST = 16'd150;
  localparam logic [15:0] ECHO_TIMEOUT_RST  = 16'd64000;
  localparam logic [7:0]  STOP_THRESH_RST   = 8'd10;

  // Distance is count * SCALE_MUL / SCALE_DIV, tracked as quotient and remainder.
  localparam int          QUOT_W    = 6;
  localparam int          REM_W     = 15;
  localparam logic [REM_W-1:0] SCALE_MUL = 15'd17;
  localparam logic [REM_W-1:0] SCALE_DIV = 15'd22118;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] trigger_ticks;
    logic [15:0] echo_timeout_ticks;
    logic [7:0]  stop_threshold;
  } cfg_t;

  typedef struct packed {
    logic start_req;
    logic echo_level;
  } in_item_t;

  typedef struct packed {
    logic       trigger_level;
    logic       done_res;
    logic [7:0] distance_cm;
    logic       timed_out;
    logic       motor_stop;
    logic       busy_res;
  } out_item_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_WAIT = 4'b0100,
    PH_MEAS = 4'b1000
  } phase_t;

endpackage

[hdl/urs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urs_ctrl: measurement sequencer
// Holds the phase, tick counter and last result; advances once per accepted
// item and presents the result item for that tick.
// ----------------------------------------------------------------------------
module urs_ctrl import urs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t res
);

  phase_t            phase, phase_next;
  logic [15:0]       tick_count, tick_count_next;
  logic [QUOT_W-1:0] quot, quot_next;
  logic [REM_W-1:0]  rem, rem_next;
  logic [7:0]        last_distance, last_distance_next;
  logic              timeout_flag, timeout_flag_next;
  logic              stop_flag, stop_flag_next;
  logic              done;
  logic [15:0]       wait_inc;
  logic [REM_W-1:0]  rem_add;

  assign wait_inc = tick_count + 16'd1;
  assign rem_add  = rem + SCALE_MUL;

  // Next-state logic for one tick.
  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    quot_next          = quot;
    rem_next           = rem;
    last_distance_next = last_distance;
    timeout_flag_next  = timeout_flag;
    stop_flag_next     = stop_flag;
    done               = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (item.start_req) begin
          phase_next      = PH_TRIG;
          tick_count_next = 16'd1;
        end
      end
      PH_TRIG: begin
        if (tick_count >= cfg.trigger_ticks) begin
          phase_next      = PH_WAIT;
          tick_count_next = '0;
        end else begin
          tick_count_next = wait_inc;
        end
      end
      PH_WAIT: begin
        if (item.echo_level) begin
          // The rise tick is the first counted tick.
          phase_next      = PH_MEAS;
          tick_count_next = 16'd1;
          quot_next       = '0;
          rem_next        = SCALE_MUL;
        end else if (wait_inc >= cfg.echo_timeout_ticks || wait_inc == '0) begin
          phase_next         = PH_IDLE;
          tick_count_next    = '0;
          last_distance_next = '0;
          timeout_flag_next  = 1'b1;
          stop_flag_next     = (cfg.stop_threshold != 8'd0);
          done               = 1'b1;
        end else begin
          tick_count_next = wait_inc;
        end
      end
      PH_MEAS: begin
        if (item.echo_level) begin
          // Saturating count with the scaled distance kept up to date.
          if (tick_count < COUNT_MAX) begin
            tick_count_next = wait_inc;
            if (rem_add >= SCALE_DIV) begin
              rem_next  = rem_add - SCALE_DIV;
              quot_next = quot + QUOT_W'(1);
            end else begin
              rem_next = rem_add;
            end
          end
        end else begin
          phase_next         = PH_IDLE;
          tick_count_next    = '0;
          quot_next          = '0;
          rem_next           = '0;
          last_distance_next = 8'(quot);
          timeout_flag_next  = 1'b0;
          stop_flag_next     = (8'(quot) < cfg.stop_threshold);
          done               = 1'b1;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // State registers advance only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      quot          <= '0;
      rem           <= '0;
      last_distance <= '0;
      timeout_flag  <= 1'b0;
      stop_flag     <= 1'b0;
    end else if (en) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      quot          <= quot_next;
      rem           <= rem_next;
      last_distance <= last_distance_next;
      timeout_flag  <= timeout_flag_next;
      stop_flag     <= stop_flag_next;
    end
  end

  // Result item reflects the state after this tick.
  always_comb begin
    res.trigger_level = (phase_next == PH_TRIG);
    res.done_res      = done;
    res.distance_cm   = last_distance_next;
    res.timed_out     = timeout_flag_next;
    res.motor_stop    = stop_flag_next;
    res.busy_res      = (phase_next != PH_IDLE);
  end

  // A finished measurement always leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    (en && done) |=> (phase == PH_IDLE))
    else $error("sequencer not idle after a finished measurement");

  // The running remainder stays below the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    rem < SCALE_DIV)
    else $error("distance remainder out of range");

  // Idle carries no leftover count or partial distance.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (tick_count == '0 && quot == '0 && rem == '0))
    else $error("idle phase holds stale count");

endmodule

[hdl/ultrasonic_range_obstacle_stop_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_range_obstacle_stop_core: echo ranging with obstacle stop
// One input item per timer tick drives the trigger/echo sequencer; each item
// yields one result item with trigger level, distance and motor stop.
// ----------------------------------------------------------------------------
//  Channel  Signals                                Direction  Item
//  in       in_valid / in_stall / in_data          input      in_item_t
//  out      out_valid / out_stall / out_data       output     out_item_t
//  cfg      psel penable pwrite paddr pwdata ...   APB        32-bit data
//
//  The sequencer updates at the accepting edge and the result item sits in
//  the output register from the next cycle.
//  One item is accepted per cycle while out_stall is low, set by the single output register.
//  in_stall is high only while a result item is held and out_stall is high.
//  Reset is synchronous on rst; configuration returns to its reset values.
// ----------------------------------------------------------------------------
module ultrasonic_range_obstacle_stop_core import urs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t                 cfg;
  out_item_t            res;
  logic                 accept;
  logic                 cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_ticks      <= TRIGGER_TICKS_RST;
      cfg.echo_timeout_ticks <= ECHO_TIMEOUT_RST;
      cfg.stop_threshold     <= STOP_THRESH_RST;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_TRIGGER_TICKS: cfg.trigger_ticks      <= pwdata[15:0];
        REG_ECHO_TIMEOUT:  cfg.echo_timeout_ticks <= pwdata[15:0];
        REG_STOP_THRESH:   cfg.stop_threshold     <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      REG_TRIGGER_TICKS: prdata = {16'd0, cfg.trigger_ticks};
      REG_ECHO_TIMEOUT:  prdata = {16'd0, cfg.echo_timeout_ticks};
      REG_STOP_THRESH:   prdata = {24'd0, cfg.stop_threshold};
      default:           prdata = '0;
    endcase
  end

  // Input is taken whenever the output register is free or draining.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  urs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .en   (accept),
    .item (in_data),
    .cfg  (cfg),
    .res  (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= res;
    end
  end

  // Every accepted item shows up as a result item in the next cycle.
  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result item");

  // A held result item is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("held result item was lost or changed");

  // Input backpressure only comes from a full output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with free output register");

endmodule
